// File: hw/rtl/trsm_pkg.sv
`timescale 1ns / 1ps

package trsm_pkg;

  localparam int PTR_W   = 6;
  localparam int CNT_W   = 7;
  localparam int EB_W    = 13;
  localparam int OFS_W   = 18;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 1;

  // pointer and count widths above are sized for this ring depth
  localparam int MAX_SLOTS = 64;

  localparam logic [EB_W-1:0] EB_LIMIT = EB_W'(4096);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CONSUME = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNAVAIL = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ORDER   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 1'd1;

  typedef struct packed {
    logic [PTR_W-1:0] read_pointer;
    logic [PTR_W-1:0] commit_pointer;
    logic [PTR_W-1:0] acquire_pointer;
    logic [PTR_W-1:0] release_pointer;
    logic [CNT_W-1:0] ready_count;
    logic [CNT_W-1:0] acquired_count;
    logic [CNT_W-1:0] held_count;
  } ring_state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PTR_W-1:0]  slot_out;
    logic [OFS_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  committed_count;
  } ring_result_t;

endpackage

// File: hw/rtl/trsm_step.sv
`timescale 1ns / 1ps

module trsm_step (
  input  trsm_pkg::ring_state_t          st,
  input  logic [trsm_pkg::KIND_W-1:0]    kind,
  input  logic                           allow_overwrite,
  input  logic [trsm_pkg::PTR_W-1:0]     slot_given,
  input  logic [trsm_pkg::CNT_W-1:0]     wrap,
  input  logic [trsm_pkg::EB_W-1:0]      element_bytes,
  output trsm_pkg::ring_state_t          st_next,
  output trsm_pkg::ring_result_t         res
);
  import trsm_pkg::*;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] n;
    n = {1'b0, p} + CNT_W'(1);
    return (n >= w) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] wm1;
    wm1 = w - CNT_W'(1);
    return (p == '0) ? wm1[PTR_W-1:0] : p - PTR_W'(1);
  endfunction

  logic [CNT_W+1:0]  in_use;
  logic              full;
  logic [PTR_W-1:0]  disc_slot;
  logic [PTR_W-1:0]  slot;
  logic [STAT_W-1:0] status;
  logic              grant;
  logic [EB_W-1:0]   eb_clamped;
  logic [PTR_W+EB_W-1:0] product;

  assign in_use = (CNT_W+2)'(st.acquired_count) + (CNT_W+2)'(st.ready_count)
                + (CNT_W+2)'(st.held_count);
  assign full      = in_use >= (CNT_W+2)'(wrap);
  assign disc_slot = ptr_prev(st.acquire_pointer, wrap);

  always_comb begin
    st_next = st;
    status  = ST_OK;
    slot    = '0;
    grant   = 1'b0;
    unique case (kind)
      KIND_ACQUIRE: begin
        priority if (full && !allow_overwrite) begin
          status = ST_UNAVAIL;
        end else if (full && (st.ready_count == '0 || st.held_count != '0 ||
                              st.release_pointer != st.read_pointer)) begin
          status = ST_BLOCKED;
        end else begin
          // drop the oldest committed slot to make room
          if (full) begin
            st_next.read_pointer    = ptr_next(st.read_pointer, wrap);
            st_next.release_pointer = ptr_next(st.release_pointer, wrap);
            st_next.ready_count     = st.ready_count - CNT_W'(1);
          end
          slot  = st.acquire_pointer;
          grant = 1'b1;
          st_next.acquire_pointer = ptr_next(st.acquire_pointer, wrap);
          st_next.acquired_count  = st.acquired_count + CNT_W'(1);
        end
      end
      KIND_COMMIT: begin
        priority if (st.acquired_count == '0) begin
          status = ST_NONE;
        end else if (slot_given != st.commit_pointer) begin
          status = ST_ORDER;
        end else begin
          st_next.commit_pointer = ptr_next(st.commit_pointer, wrap);
          st_next.ready_count    = st.ready_count + CNT_W'(1);
          st_next.acquired_count = st.acquired_count - CNT_W'(1);
        end
      end
      KIND_DISCARD: begin
        priority if (st.acquired_count == '0) begin
          status = ST_NONE;
        end else if (slot_given != disc_slot) begin
          status = ST_ORDER;
        end else begin
          st_next.acquire_pointer = disc_slot;
          st_next.acquired_count  = st.acquired_count - CNT_W'(1);
        end
      end
      KIND_PEEK, KIND_CONSUME: begin
        if (st.ready_count == '0) begin
          status = ST_UNAVAIL;
        end else begin
          slot  = st.read_pointer;
          grant = 1'b1;
          if (kind == KIND_CONSUME) begin
            st_next.read_pointer = ptr_next(st.read_pointer, wrap);
            st_next.ready_count  = st.ready_count - CNT_W'(1);
            st_next.held_count   = st.held_count + CNT_W'(1);
          end
        end
      end
      KIND_RELEASE: begin
        priority if (st.held_count == '0) begin
          status = ST_NONE;
        end else if (slot_given != st.release_pointer) begin
          status = ST_ORDER;
        end else begin
          st_next.release_pointer = ptr_next(st.release_pointer, wrap);
          st_next.held_count      = st.held_count - CNT_W'(1);
        end
      end
      default: begin
        status = ST_UNAVAIL;
      end
    endcase
  end

  assign eb_clamped = (element_bytes > EB_LIMIT) ? EB_LIMIT : element_bytes;
  assign product    = (PTR_W+EB_W)'(grant ? slot : '0) * (PTR_W+EB_W)'(eb_clamped);

  assign res.status          = status;
  assign res.slot_out        = grant ? slot : '0;
  assign res.byte_offset     = product[OFS_W-1:0];
  assign res.committed_count = st_next.ready_count;

endmodule

// File: hw/rtl/two_phase_ring_slot_manager_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// request  in         in_valid / in_stall    kind, allow_overwrite, slot_given
// result   out        out_valid / out_stall  status, slot_out, byte_offset,
//                                            committed_count
//
// One item per cycle while in_stall is low: each request is decoded against the ring
// pointers and counts and lands in the result register on the edge that accepts it,
// so its result appears in the next cycle. in_stall follows out_stall only
// while the result register holds an item not yet taken. rst (synchronous)
// empties the ring, drops any pending result and restores slots_in_use = 64,
// element_bytes = 1. Configuration writes are always taken (cfg_ready high).

module two_phase_ring_slot_manager_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trsm_pkg::EB_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [trsm_pkg::KIND_W-1:0]       kind,
  input  logic                              allow_overwrite,
  input  logic [trsm_pkg::PTR_W-1:0]        slot_given,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [trsm_pkg::STAT_W-1:0]       status,
  output logic [trsm_pkg::PTR_W-1:0]        slot_out,
  output logic [trsm_pkg::OFS_W-1:0]        byte_offset,
  output logic [trsm_pkg::CNT_W-1:0]        committed_count
);
  import trsm_pkg::*;

  logic [CNT_W-1:0] slots_in_use;
  logic [EB_W-1:0]  element_bytes;
  logic [CNT_W-1:0] wrap;
  ring_state_t      state;
  ring_state_t      state_next;
  ring_result_t     res;
  ring_result_t     result;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;

  // clamp the wrap point into 1..MAX_SLOTS
  always_comb begin
    priority if (slots_in_use == '0) begin
      wrap = CNT_W'(1);
    end else if (int'(slots_in_use) > MAX_SLOTS) begin
      wrap = CNT_W'(MAX_SLOTS);
    end else begin
      wrap = slots_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use  <= CNT_W'(64);
      element_bytes <= EB_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE:  slots_in_use  <= cfg_data[CNT_W-1:0];
        CFG_ELEMENT_BYTES: element_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  trsm_step u_step (
    .st              (state),
    .kind            (kind),
    .allow_overwrite (allow_overwrite),
    .slot_given      (slot_given),
    .wrap            (wrap),
    .element_bytes   (element_bytes),
    .st_next         (state_next),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state <= state_next;
      end
      // hold the result while stalled, drop it once taken
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= res;
    end
  end

  assign status          = result.status;
  assign slot_out        = result.slot_out;
  assign byte_offset     = result.byte_offset;
  assign committed_count = result.committed_count;

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.status != ST_OK |=> state == $past(state))
    else $error("refused request changed ring state");

  a_count_matches_state: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> committed_count == state.ready_count)
    else $error("committed_count disagrees with ready count");

  a_no_slot_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> slot_out == '0 && byte_offset == '0)
    else $error("slot reported on refused request");

  a_one_step_per_item: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> state == $past(state))
    else $error("ring state moved without an item");

endmodule

// File: dv/two_phase_ring_slot_manager_core_tb.sv
`timescale 1ns / 1ps

module two_phase_ring_slot_manager_core_tb;
  import trsm_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int ITEMS_PER_SETTING = 115;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             is_cfg;
    logic [EB_W-1:0]  slots_val;
    logic [EB_W-1:0]  eb_val;
    logic [KIND_W-1:0] k;
    logic             ow;
    logic [PTR_W-1:0] given;
    logic             has_exp;
    ring_result_t     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [EB_W-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    req_kind = '0;
  logic                 req_overwrite = 1'b0;
  logic [PTR_W-1:0]     req_slot = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    res_status;
  logic [PTR_W-1:0]     res_slot;
  logic [OFS_W-1:0]     res_offset;
  logic [CNT_W-1:0]     res_count;

  // ring bookkeeping mirrored from the accepted requests
  logic [CNT_W-1:0] cfg_slots = 7'd64;
  logic [EB_W-1:0]  cfg_eb = 13'd1;
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] cm_ptr = '0;
  logic [PTR_W-1:0] aq_ptr = '0;
  logic [PTR_W-1:0] rl_ptr = '0;
  logic [CNT_W-1:0] n_ready = '0;
  logic [CNT_W-1:0] n_acquired = '0;
  logic [CNT_W-1:0] n_held = '0;

  ring_result_t pending_results[$];
  stim_row_t    stim_table[$];
  ring_result_t want;
  int err_count = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 70;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;

  two_phase_ring_slot_manager_core i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(req_kind),
    .allow_overwrite(req_overwrite),
    .slot_given(req_slot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(res_status),
    .slot_out(res_slot),
    .byte_offset(res_offset),
    .committed_count(res_count)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("** two_phase_ring_slot_manager_core: FAILED **");
    $finish;
  end

  function automatic int wrap_now();
    int w;
    w = int'(cfg_slots);
    if (w == 0) w = 1;
    if (w > MAX_SLOTS) w = MAX_SLOTS;
    return w;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    int n;
    n = int'(p) + 1;
    return (n >= wrap_now()) ? '0 : PTR_W'(n);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(wrap_now() - 1) : p - PTR_W'(1);
  endfunction

  // Apply one request to the mirrored ring and return the result it gives.
  function automatic ring_result_t next_ring_result(input logic [KIND_W-1:0] k,
                                                    input logic ow,
                                                    input logic [PTR_W-1:0] g);
    ring_result_t r;
    logic grant;
    logic full;
    logic [PTR_W-1:0] slot;
    int ebytes;
    r = '0;
    grant = 1'b0;
    slot = '0;
    r.status = ST_OK;
    case (k)
      KIND_ACQUIRE: begin
        full = (int'(n_acquired) + int'(n_ready) + int'(n_held)) >= wrap_now();
        if (full && !ow) begin
          r.status = ST_UNAVAIL;
        end else if (full && (n_ready == '0 || n_held != '0 || rl_ptr != rd_ptr)) begin
          r.status = ST_BLOCKED;
        end else begin
          if (full) begin
            // drop the oldest committed slot
            rd_ptr = ptr_inc(rd_ptr);
            rl_ptr = ptr_inc(rl_ptr);
            n_ready = n_ready - CNT_W'(1);
          end
          slot = aq_ptr;
          grant = 1'b1;
          aq_ptr = ptr_inc(aq_ptr);
          n_acquired = n_acquired + CNT_W'(1);
        end
      end
      KIND_COMMIT: begin
        if (n_acquired == '0) begin
          r.status = ST_NONE;
        end else if (g != cm_ptr) begin
          r.status = ST_ORDER;
        end else begin
          cm_ptr = ptr_inc(cm_ptr);
          n_ready = n_ready + CNT_W'(1);
          n_acquired = n_acquired - CNT_W'(1);
        end
      end
      KIND_DISCARD: begin
        if (n_acquired == '0) begin
          r.status = ST_NONE;
        end else if (g != ptr_dec(aq_ptr)) begin
          r.status = ST_ORDER;
        end else begin
          aq_ptr = ptr_dec(aq_ptr);
          n_acquired = n_acquired - CNT_W'(1);
        end
      end
      KIND_PEEK, KIND_CONSUME: begin
        if (n_ready == '0) begin
          r.status = ST_UNAVAIL;
        end else begin
          slot = rd_ptr;
          grant = 1'b1;
          if (k == KIND_CONSUME) begin
            rd_ptr = ptr_inc(rd_ptr);
            n_ready = n_ready - CNT_W'(1);
            n_held = n_held + CNT_W'(1);
          end
        end
      end
      KIND_RELEASE: begin
        if (n_held == '0) begin
          r.status = ST_NONE;
        end else if (g != rl_ptr) begin
          r.status = ST_ORDER;
        end else begin
          rl_ptr = ptr_inc(rl_ptr);
          n_held = n_held - CNT_W'(1);
        end
      end
      default: r.status = ST_UNAVAIL;
    endcase
    ebytes = (cfg_eb > EB_LIMIT) ? int'(EB_LIMIT) : int'(cfg_eb);
    if (!grant) slot = '0;
    r.slot_out = slot;
    r.byte_offset = OFS_W'(int'(slot) * ebytes);
    r.committed_count = n_ready;
    return r;
  endfunction

  function automatic stim_row_t row_req(input logic [KIND_W-1:0] k, input logic ow,
                                        input logic [PTR_W-1:0] g);
    stim_row_t s;
    s = '0;
    s.k = k;
    s.ow = ow;
    s.given = g;
    return s;
  endfunction

  function automatic stim_row_t row_exp(input logic [KIND_W-1:0] k, input logic ow,
                                        input logic [PTR_W-1:0] g,
                                        input logic [STAT_W-1:0] st,
                                        input logic [PTR_W-1:0] slot,
                                        input logic [OFS_W-1:0] ofs,
                                        input logic [CNT_W-1:0] cnt);
    stim_row_t s;
    s = row_req(k, ow, g);
    s.has_exp = 1'b1;
    s.res = '{status: st, slot_out: slot, byte_offset: ofs, committed_count: cnt};
    return s;
  endfunction

  function automatic stim_row_t row_cfg(input logic [EB_W-1:0] slots,
                                        input logic [EB_W-1:0] eb);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.slots_val = slots;
    s.eb_val = eb;
    return s;
  endfunction

  // Hold the request channel quiet until every result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(input logic [EB_W-1:0] slots, input logic [EB_W-1:0] eb);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SLOTS_IN_USE;
    cfg_data <= slots;
    do @(posedge clk); while (!cfg_ready);
    cfg_slots = slots[CNT_W-1:0];
    cfg_index <= CFG_ELEMENT_BYTES;
    cfg_data <= eb;
    do @(posedge clk); while (!cfg_ready);
    cfg_eb = eb;
    cfg_valid <= 1'b0;
  endtask

  task automatic offer(input logic [KIND_W-1:0] k, input logic ow,
                       input logic [PTR_W-1:0] g, input logic has_exp,
                       input ring_result_t fixed_res);
    ring_result_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_kind <= k;
    req_overwrite <= ow;
    req_slot <= g;
    do @(posedge clk); while (in_stall);
    r = next_ring_result(k, ow, g);
    pending_results.push_back(has_exp ? fixed_res : r);
  endtask

  // Mostly in-order slot hand-backs so the ring actually cycles; the rest is noise.
  task automatic pick_request(output logic [KIND_W-1:0] k, output logic ow,
                              output logic [PTR_W-1:0] g);
    int r;
    logic sane;
    r = $urandom_range(0, 99);
    sane = $urandom_range(0, 99) < 85;
    ow = $urandom_range(0, 99) < 60;
    g = PTR_W'($urandom_range(0, 63));
    if (r < 28) begin
      k = KIND_ACQUIRE;
    end else if (r < 46) begin
      k = KIND_COMMIT;
      if (sane) g = cm_ptr;
    end else if (r < 54) begin
      k = KIND_DISCARD;
      if (sane) g = ptr_dec(aq_ptr);
    end else if (r < 62) begin
      k = KIND_PEEK;
    end else if (r < 78) begin
      k = KIND_CONSUME;
    end else if (r < 95) begin
      k = KIND_RELEASE;
      if (sane) g = rl_ptr;
    end else if (r < 98) begin
      k = KIND_SPARE_LO;
    end else begin
      k = KIND_SPARE_HI;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d slot %0d offset %0d count %0d",
                   $time, res_status, res_slot, res_offset, res_count);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (res_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, res_status);
            err_count++;
          end
          if (res_slot !== want.slot_out) begin
            $display("%0t: slot_out expected %0d, got %0d", $time, want.slot_out, res_slot);
            err_count++;
          end
          if (res_offset !== want.byte_offset) begin
            $display("%0t: byte_offset expected %0d, got %0d",
                     $time, want.byte_offset, res_offset);
            err_count++;
          end
          if (res_count !== want.committed_count) begin
            $display("%0t: committed_count expected %0d, got %0d",
                     $time, want.committed_count, res_count);
            err_count++;
          end
        end
      end
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t row;
    int ph;
    int n;
    logic [KIND_W-1:0] k;
    logic ow;
    logic [PTR_W-1:0] g;

    // empty ring at reset values
    stim_table.push_back(row_exp(KIND_PEEK, 1'b0, 6'd0, ST_UNAVAIL, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_CONSUME, 1'b1, 6'd63, ST_UNAVAIL, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_COMMIT, 1'b0, 6'd0, ST_NONE, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_DISCARD, 1'b0, 6'd63, ST_NONE, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_RELEASE, 1'b1, 6'd63, ST_NONE, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_SPARE_LO, 1'b0, 6'd0, ST_UNAVAIL, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_SPARE_HI, 1'b1, 6'd63, ST_UNAVAIL, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_ACQUIRE, 1'b0, 6'd0, ST_OK, 6'd0, 18'd0, 7'd0));
    // two-slot ring: full, blocked overwrite, order errors, real overwrite
    stim_table.push_back(row_cfg(13'd2, 13'd4096));
    stim_table.push_back(row_req(KIND_ACQUIRE, 1'b1, 6'd0));
    stim_table.push_back(row_exp(KIND_ACQUIRE, 1'b0, 6'd0, ST_UNAVAIL, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_ACQUIRE, 1'b1, 6'd0, ST_BLOCKED, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_exp(KIND_COMMIT, 1'b0, 6'd1, ST_ORDER, 6'd0, 18'd0, 7'd0));
    stim_table.push_back(row_req(KIND_COMMIT, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_DISCARD, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_DISCARD, 1'b0, 6'd1));
    stim_table.push_back(row_req(KIND_ACQUIRE, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_ACQUIRE, 1'b1, 6'd0));
    stim_table.push_back(row_req(KIND_COMMIT, 1'b0, 6'd1));
    stim_table.push_back(row_req(KIND_COMMIT, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_CONSUME, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_ACQUIRE, 1'b1, 6'd0));
    stim_table.push_back(row_req(KIND_RELEASE, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_RELEASE, 1'b0, 6'd1));
    // zero slots acts as one, oversized element size saturates
    stim_table.push_back(row_cfg(13'd0, 13'd8191));
    stim_table.push_back(row_req(KIND_PEEK, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_CONSUME, 1'b0, 6'd0));
    // oversized slot count saturates, zero element size
    stim_table.push_back(row_cfg(13'd127, 13'd0));
    stim_table.push_back(row_req(KIND_ACQUIRE, 1'b0, 6'd0));
    stim_table.push_back(row_req(KIND_CONSUME, 1'b1, 6'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_cfg) begin
        drain_results();
        write_regs(row.slots_val, row.eb_val);
      end else begin
        offer(row.k, row.ow, row.given, row.has_exp, row.res);
      end
    end

    for (ph = 0; ph < 9; ph++) begin
      drain_results();
      case (ph)
        0: write_regs(13'd2, 13'd4096);
        1: write_regs(13'd64, 13'd1);
        2: write_regs(13'd5, 13'd8191);
        3: write_regs(13'd1, 13'd0);
        4: write_regs(13'd127, 13'd4095);
        5: write_regs(13'h1F83, 13'd3);
        6: write_regs(13'd0, 13'd4096);
        7: write_regs(13'd17, EB_W'($urandom_range(0, 8191)));
        default: write_regs(EB_W'($urandom_range(1, 64)), 13'd1);
      endcase
      send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 70 : 0;
      recv_idle_pct = (ph < 3) ? 70 : (ph < 6) ? 8 : 0;
      // long receiver hold-off while requests keep coming
      if (ph == 6) hold_trigger++;
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (ph == 7 && n == ITEMS_PER_SETTING / 2) drain_results();
        pick_request(k, ow, g);
        offer(k, ow, g, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("** two_phase_ring_slot_manager_core: PASSED **");
    end else begin
      $display("** two_phase_ring_slot_manager_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: two_phase_ring_slot_manager_core.f
hw/rtl/trsm_pkg.sv
hw/rtl/trsm_step.sv
hw/rtl/two_phase_ring_slot_manager_core.sv
dv/two_phase_ring_slot_manager_core_tb.sv
